// ===== rtl/dlerx_pkg.sv =====
// Shared constants, byte codes and the CRC-16 byte update for the DLE/STX frame receiver.
package dlerx_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned PosW   = 17;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;  // data_byte, text_length
  localparam int unsigned OutUserW = 2;   // is_text, crc_ok

  localparam logic [ByteW-1:0] CODE_DLE = 8'h10;
  localparam logic [ByteW-1:0] CODE_STX = 8'h02;
  localparam logic [ByteW-1:0] CODE_ETX = 8'h03;
  localparam logic [CrcW-1:0]  CRC_POLY = 16'h8408;

  // Frame positions that have a fixed meaning (count of bytes taken, from 1).
  localparam logic [PosW-1:0] POS_FIRST = 17'd1;
  localparam logic [PosW-1:0] POS_STX   = 17'd2;
  localparam logic [PosW-1:0] POS_LEN_H = 17'd3;
  localparam logic [PosW-1:0] POS_LEN_L = 17'd4;

  // Reflected CRC-16, one byte, LSB first.
  function automatic logic [CrcW-1:0] crc_add_byte(input logic [CrcW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/dle_stx_frame_receiver_crc16_core.sv =====
// DLE/STX length-framed byte receiver with CRC-16 check, stream in and stream out.
// Each accepted input transaction is registered; its result is on out_* in the next cycle.
// Throughput: one byte per cycle unless stalled; the frame state and the unrolled 8-bit
//   CRC update sit in the single stage between input handshake and output register.
// in_tready stays high while the output register is empty or being drained.
// Reset (rst_n low, synchronous): frame search restarts, CRC and length clear,
//   output register is emptied.
module dle_stx_frame_receiver_crc16_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dlerx_pkg::InDataW-1:0]    in_tdata,   // [7:0] rx_byte
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dlerx_pkg::OutDataW-1:0]   out_tdata,  // [7:0] data_byte, [23:8] text_length
  output logic [dlerx_pkg::OutUserW-1:0]   out_tuser,  // [0] is_text, [1] crc_ok
  output logic                             out_tlast   // frame_done
);
  import dlerx_pkg::*;

  // frame tracking state
  logic [PosW-1:0]  byte_pos_r,  byte_pos_nxt;
  logic             first_dle_r, first_dle_nxt;
  logic [LenW-1:0]  len_r,       len_nxt;
  logic [CrcW-1:0]  crc_r,       crc_nxt;
  logic [ByteW-1:0] crc_lo_r,    crc_lo_nxt;

  // output register
  logic             out_vld_r;
  logic [ByteW-1:0] out_byte_r;
  logic [LenW-1:0]  out_len_r;
  logic             out_text_r, out_done_r, out_ok_r;

  logic             in_acc;
  logic [ByteW-1:0] rx_byte;
  logic [PosW-1:0]  pos;
  logic [PosW-1:0]  len_ext;
  logic [CrcW-1:0]  crc_upd;
  logic             text, done, ok;

  // Output slot frees up the same cycle it is drained, so bytes stream back to back.
  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign rx_byte   = in_tdata[ByteW-1:0];
  assign len_ext   = {{(PosW-LenW){1'b0}}, len_r};
  assign crc_upd   = crc_add_byte(crc_r, rx_byte);

  // Position decode for the byte being accepted. Text occupies positions 5..L+4,
  // the two trailer bytes (nominally DLE ETX, not checked) L+5..L+6, CRC low at L+7,
  // CRC high closes the frame.
  always_comb begin
    pos           = byte_pos_r + PosW'(1);
    first_dle_nxt = first_dle_r;
    len_nxt       = len_r;
    crc_nxt       = crc_r;
    crc_lo_nxt    = crc_lo_r;
    text          = 1'b0;
    done          = 1'b0;
    ok            = 1'b0;
    if (pos == POS_FIRST) begin
      first_dle_nxt = (rx_byte == CODE_DLE);
      len_nxt       = '0;
      crc_nxt       = '0;
    end else if (pos == POS_STX) begin
      // bad start: drop both bytes and hunt again
      if (!(first_dle_r && rx_byte == CODE_STX)) begin
        pos = '0;
      end
    end else if (pos == POS_LEN_H) begin
      len_nxt = {{(LenW-ByteW){1'b0}}, rx_byte};
      crc_nxt = crc_upd;
    end else if (pos == POS_LEN_L) begin
      len_nxt = {len_r[LenW-ByteW-1:0], rx_byte};
      crc_nxt = crc_upd;
    end else if (pos <= len_ext + PosW'(6)) begin
      text    = (pos <= len_ext + PosW'(4));
      crc_nxt = crc_upd;
    end else if (pos == len_ext + PosW'(7)) begin
      crc_lo_nxt = rx_byte;
    end else begin
      done = 1'b1;
      ok   = (crc_lo_r == crc_r[ByteW-1:0]) && (rx_byte == crc_r[CrcW-1:ByteW]);
      pos  = '0;
    end
    byte_pos_nxt = pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      first_dle_r <= 1'b0;
      len_r       <= '0;
      crc_r       <= '0;
      crc_lo_r    <= '0;
    end else if (in_acc) begin
      byte_pos_r  <= byte_pos_nxt;
      first_dle_r <= first_dle_nxt;
      len_r       <= len_nxt;
      crc_r       <= crc_nxt;
      crc_lo_r    <= crc_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_byte_r <= rx_byte;
      out_len_r  <= len_nxt;
      out_text_r <= text;
      out_done_r <= done;
      out_ok_r   <= ok;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_len_r, out_byte_r};
  assign out_tuser  = {out_ok_r, out_text_r};
  assign out_tlast  = out_done_r;

endmodule

// ===== rtl/dlerx_checker.sv =====
// Port-level checker for the DLE/STX frame receiver, bound to the top level.
module dlerx_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [dlerx_pkg::InDataW-1:0]    in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dlerx_pkg::OutDataW-1:0]   out_tdata,
  input logic [dlerx_pkg::OutUserW-1:0]   out_tuser,
  input logic                             out_tlast
);
  import dlerx_pkg::*;

  // crc_ok only ever comes with the frame end
  a_ok_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("crc_ok without frame_done");

  // a text byte is never the closing CRC byte
  a_text_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tlast)
    else $error("text byte flagged as frame end");

  // every accepted byte shows up on the next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid && out_tdata[ByteW-1:0] == $past(in_tdata))
    else $error("accepted byte not echoed one cycle later");

  // stalled result holds
  a_out_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind dle_stx_frame_receiver_crc16_core dlerx_checker u_dlerx_checker (.*);
